// ----- rtl/lpht_pkg.sv -----
package lpht_pkg;

  // Table geometry.
  localparam int TABLE_SLOTS   = 2048;
  localparam int SLOT_BITS     = $clog2(TABLE_SLOTS);
  localparam int STEP_BITS     = $clog2(TABLE_SLOTS + 1);
  localparam int OUT_IDX_BITS  = 11;

  // Hash window.
  localparam int HASH_TAIL_BYTES = 20;
  localparam int TAIL_IDX_BITS   = (HASH_TAIL_BYTES > 1) ? $clog2(HASH_TAIL_BYTES) : 1;
  localparam int TAIL_CNT_BITS   = $clog2(HASH_TAIL_BYTES + 1);

  // Key buffering.
  localparam int MAX_KEY_BYTES = 64;
  localparam int KEY_CNT_BITS  = $clog2(MAX_KEY_BYTES + 1);
  localparam int KEY_POS_BITS  = $clog2(MAX_KEY_BYTES);
  localparam int KEY_WORDS     = (MAX_KEY_BYTES + 7) / 8;
  localparam int KW_BITS       = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam int KEY_RAM_DEPTH = TABLE_SLOTS * (1 << KW_BITS);
  localparam int KEY_RAM_ABITS = SLOT_BITS + KW_BITS;
  localparam int META_BITS     = 1 + KEY_CNT_BITS;

  // Modular hash arithmetic.
  localparam int          HASH_BITS = 30;
  localparam int          ACC_BITS  = 35;
  localparam logic [ACC_BITS-1:0] HASH_MOD = 35'd1000000009;

  // Request kinds.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  // Result status codes.
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_REJECTED  = 3'd4;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  key_byte;
    logic        key_last;
    logic [63:0] record_value;
  } in_req_t;

  typedef struct packed {
    logic [2:0]              status;
    logic [OUT_IDX_BITS-1:0] slot_index;
    logic [63:0]             found_value;
  } out_rsp_t;

  // Control from the sequencer to the hash unit.
  typedef struct packed {
    logic                     push;
    logic                     clear;
    logic                     go;
    logic [7:0]               key_byte;
    logic [TAIL_CNT_BITS-1:0] n_bytes;
  } hash_ctl_t;

  // Status from the hash unit.
  typedef struct packed {
    logic                 done;
    logic [SLOT_BITS-1:0] home_slot;
  } hash_sts_t;

endpackage

// ----- rtl/lpht_ram.sv -----
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/lpht_hash.sv -----
module lpht_hash (
  input  logic               clk,
  input  logic               rst_n,
  input  lpht_pkg::hash_ctl_t ctl,
  output lpht_pkg::hash_sts_t sts
);

  logic [7:0]                         win_r [lpht_pkg::HASH_TAIL_BYTES];
  logic [lpht_pkg::ACC_BITS-1:0]      x_r, x_nxt;
  logic [lpht_pkg::TAIL_IDX_BITS-1:0] j_r, j_nxt;
  logic [lpht_pkg::TAIL_CNT_BITS-1:0] left_r, left_nxt;
  logic                               run_r, run_nxt;
  logic                               red_r, red_nxt;
  logic                               done_r, done_nxt;
  logic [4:0]                         q;
  logic [lpht_pkg::ACC_BITS-1:0]      qm;
  logic [lpht_pkg::ACC_BITS-1:0]      h_ext;

  // Window of the most recent key bytes; the newest sits at the top.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      for (int i = 0; i < lpht_pkg::HASH_TAIL_BYTES; i++) begin
        win_r[i] <= 8'd0;
      end
    end else if (ctl.push) begin
      for (int i = 0; i < lpht_pkg::HASH_TAIL_BYTES - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[lpht_pkg::HASH_TAIL_BYTES-1] <= ctl.key_byte;
    end
  end

  // Horner evaluation from the newest byte down, one multiply-add then a few
  // partial reductions per byte through the same subtractor.
  always_comb begin
    q     = x_r[lpht_pkg::ACC_BITS-1:lpht_pkg::HASH_BITS];
    qm    = (q == 5'd0) ? lpht_pkg::HASH_MOD
                        : lpht_pkg::ACC_BITS'(lpht_pkg::ACC_BITS'(q) * lpht_pkg::HASH_MOD);
    h_ext = {{(lpht_pkg::ACC_BITS-lpht_pkg::HASH_BITS){1'b0}}, x_r[lpht_pkg::HASH_BITS-1:0]};
    x_nxt    = x_r;
    j_nxt    = j_r;
    left_nxt = left_r;
    run_nxt  = run_r;
    red_nxt  = red_r;
    done_nxt = 1'b0;
    if (ctl.go) begin
      x_nxt    = '0;
      j_nxt    = lpht_pkg::TAIL_IDX_BITS'(lpht_pkg::HASH_TAIL_BYTES - 1);
      left_nxt = ctl.n_bytes;
      run_nxt  = 1'b1;
      red_nxt  = 1'b0;
    end else if (run_r && !red_r) begin
      x_nxt   = (h_ext << 5) - h_ext + lpht_pkg::ACC_BITS'(win_r[j_r]);
      red_nxt = 1'b1;
    end else if (run_r) begin
      if (x_r >= lpht_pkg::HASH_MOD) begin
        x_nxt = x_r - qm;
      end else if (left_r == lpht_pkg::TAIL_CNT_BITS'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        left_nxt = left_r - lpht_pkg::TAIL_CNT_BITS'(1);
        j_nxt    = j_r - lpht_pkg::TAIL_IDX_BITS'(1);
        red_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      red_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      red_r  <= red_nxt;
      done_r <= done_nxt;
    end
    x_r    <= x_nxt;
    j_r    <= j_nxt;
    left_r <= left_nxt;
  end

  assign sts.done      = done_r;
  assign sts.home_slot = x_r[lpht_pkg::SLOT_BITS-1:0];

endmodule

// ----- rtl/linear_probe_hash_table.sv -----
// Channel   | Ports                      | Handshake
// ----------+----------------------------+--------------------------------------
// request   | start, busy, in_req        | taken at a clock edge with start & !busy
// result    | out_strobe, out_rsp        | one-cycle strobe, cannot be held off
//
// A key byte that is not the last one is buffered. The last byte runs the
// hash: per byte in the window one multiply-add, passes through the shared
// reduction subtractor and a step to the next byte; then a slot read and a
// check per probed slot, plus a key read and a compare per compared key word
// on a search and a write per key word on an insert. An oversized key
// answers at once.
// After reset the block sweeps the slot status memory, one slot a cycle, over
// all TABLE_SLOTS slots (2048) with busy high. Results cannot be stalled.
module linear_probe_hash_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  lpht_pkg::in_req_t  in_req,
  output logic               out_strobe,
  output lpht_pkg::out_rsp_t out_rsp
);

  // Sequencer states.
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_HASH  = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_CHK   = 4'd4;
  localparam logic [3:0] S_CRD   = 4'd5;
  localparam logic [3:0] S_CCHK  = 4'd6;
  localparam logic [3:0] S_WR    = 4'd7;

  logic [3:0]                         state_r, state_nxt;
  logic [lpht_pkg::KEY_CNT_BITS-1:0]  count_r, count_nxt;
  logic                               ovf_r, ovf_nxt;
  logic [63:0]                        asm_r, asm_nxt;
  logic [63:0]                        kbuf_r [lpht_pkg::KEY_WORDS];
  logic                               req_r;
  logic [63:0]                        rec_r;
  logic [lpht_pkg::KEY_CNT_BITS-1:0]  len_r;
  logic [lpht_pkg::SLOT_BITS-1:0]     idx_r, idx_nxt;
  logic [lpht_pkg::STEP_BITS-1:0]     steps_r, steps_nxt;
  logic [lpht_pkg::KW_BITS-1:0]       k_r, k_nxt;
  logic [63:0]                        rec_hold_r, rec_hold_nxt;
  logic [lpht_pkg::SLOT_BITS-1:0]     clr_r, clr_nxt;
  logic                               out_strobe_r, out_strobe_nxt;
  lpht_pkg::out_rsp_t                 out_rsp_r, out_rsp_nxt;

  logic                               accept;
  logic                               room;
  logic [lpht_pkg::KEY_POS_BITS-1:0]  pos;
  logic [lpht_pkg::KW_BITS-1:0]       pos_word;
  logic [lpht_pkg::KW_BITS-1:0]       k_last;
  logic [lpht_pkg::KEY_CNT_BITS-1:0]  len_m1;
  logic [63:0]                        kbuf_rd;
  logic                               key_done;

  lpht_pkg::hash_ctl_t                hctl;
  lpht_pkg::hash_sts_t                hsts;

  // Slot memories: status word {used, length}, record, and packed key words.
  logic                               meta_we;
  logic [lpht_pkg::SLOT_BITS-1:0]     meta_waddr;
  logic [lpht_pkg::META_BITS-1:0]     meta_wdata, meta_rd;
  logic                               rec_we;
  logic [63:0]                        rec_rd;
  logic                               key_we;
  logic [lpht_pkg::KEY_RAM_ABITS-1:0] key_addr;
  logic [63:0]                        key_rd;
  logic                               slot_used;
  logic [lpht_pkg::KEY_CNT_BITS-1:0]  slot_len;

  lpht_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (hctl),
    .sts   (hsts)
  );

  lpht_ram #(.WIDTH(lpht_pkg::META_BITS), .DEPTH(lpht_pkg::TABLE_SLOTS)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (idx_r),
    .rdata (meta_rd)
  );

  lpht_ram #(.WIDTH(64), .DEPTH(lpht_pkg::TABLE_SLOTS)) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (idx_r),
    .wdata (rec_r),
    .raddr (idx_r),
    .rdata (rec_rd)
  );

  lpht_ram #(.WIDTH(64), .DEPTH(lpht_pkg::KEY_RAM_DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_addr),
    .wdata (kbuf_rd),
    .raddr (key_addr),
    .rdata (key_rd)
  );

  assign busy       = (state_r != S_IDLE);
  assign accept     = start && !busy;
  assign out_strobe = out_strobe_r;
  assign out_rsp    = out_rsp_r;

  // Byte placement within the key buffer, packed little-endian into words.
  assign room     = (count_r < lpht_pkg::KEY_CNT_BITS'(lpht_pkg::MAX_KEY_BYTES));
  assign pos      = count_r[lpht_pkg::KEY_POS_BITS-1:0];
  assign pos_word = lpht_pkg::KW_BITS'(pos >> 3);
  assign asm_nxt  = ((pos[2:0] == 3'd0) ? 64'd0 : asm_r)
                    | (64'(in_req.key_byte) << {pos[2:0], 3'b000});

  assign len_m1   = len_r - lpht_pkg::KEY_CNT_BITS'(1);
  assign k_last   = lpht_pkg::KW_BITS'(len_m1 >> 3);
  assign kbuf_rd  = kbuf_r[k_r];
  assign key_done = (k_r == k_last);
  assign key_addr = {idx_r, k_r};

  assign slot_used = meta_rd[lpht_pkg::META_BITS-1];
  assign slot_len  = meta_rd[lpht_pkg::KEY_CNT_BITS-1:0];

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ovf_nxt        = ovf_r;
    idx_nxt        = idx_r;
    steps_nxt      = steps_r;
    k_nxt          = k_r;
    rec_hold_nxt   = rec_hold_r;
    clr_nxt        = clr_r;
    out_strobe_nxt = 1'b0;
    out_rsp_nxt    = out_rsp_r;
    meta_we        = 1'b0;
    meta_waddr     = idx_r;
    meta_wdata     = {1'b1, len_r};
    rec_we         = 1'b0;
    key_we         = 1'b0;
    hctl           = '0;
    hctl.key_byte  = in_req.key_byte;
    hctl.n_bytes   = '0;

    unique case (state_r)
      S_CLEAR: begin
        // Mark every slot empty after reset.
        meta_we    = 1'b1;
        meta_waddr = clr_r;
        meta_wdata = '0;
        clr_nxt    = clr_r + lpht_pkg::SLOT_BITS'(1);
        if (clr_r == lpht_pkg::SLOT_BITS'(lpht_pkg::TABLE_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          hctl.push = 1'b1;
          if (room) begin
            count_nxt = count_r + lpht_pkg::KEY_CNT_BITS'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_req.key_last) begin
            if (ovf_nxt) begin
              // Oversized key: answer at once and leave the table alone.
              out_strobe_nxt = 1'b1;
              out_rsp_nxt    = '{status: lpht_pkg::ST_REJECTED, slot_index: '0,
                                 found_value: '0};
              hctl.clear     = 1'b1;
              count_nxt      = '0;
              ovf_nxt        = 1'b0;
            end else begin
              hctl.go      = 1'b1;
              hctl.n_bytes = (count_nxt >= lpht_pkg::KEY_CNT_BITS'(lpht_pkg::HASH_TAIL_BYTES))
                             ? lpht_pkg::TAIL_CNT_BITS'(lpht_pkg::HASH_TAIL_BYTES)
                             : lpht_pkg::TAIL_CNT_BITS'(count_nxt);
              state_nxt    = S_HASH;
            end
          end
        end
      end
      S_HASH: begin
        if (hsts.done) begin
          idx_nxt   = hsts.home_slot;
          steps_nxt = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        k_nxt = '0;
        if (req_r == lpht_pkg::REQ_INSERT) begin
          if (!slot_used) begin
            meta_we   = 1'b1;
            rec_we    = 1'b1;
            state_nxt = S_WR;
          end else begin
            steps_nxt = steps_r + lpht_pkg::STEP_BITS'(1);
            idx_nxt   = idx_r + lpht_pkg::SLOT_BITS'(1);
            state_nxt = S_RD;
          end
        end else begin
          if (!slot_used) begin
            out_strobe_nxt = 1'b1;
            out_rsp_nxt    = '{status: lpht_pkg::ST_NOT_FOUND, slot_index: '0,
                               found_value: '0};
            state_nxt      = S_IDLE;
          end else if (slot_len != len_r) begin
            steps_nxt = steps_r + lpht_pkg::STEP_BITS'(1);
            idx_nxt   = idx_r + lpht_pkg::SLOT_BITS'(1);
            state_nxt = S_RD;
          end else begin
            rec_hold_nxt = rec_rd;
            state_nxt    = S_CRD;
          end
        end
      end
      S_CRD: begin
        state_nxt = S_CCHK;
      end
      S_CCHK: begin
        if (key_rd != kbuf_rd) begin
          steps_nxt = steps_r + lpht_pkg::STEP_BITS'(1);
          idx_nxt   = idx_r + lpht_pkg::SLOT_BITS'(1);
          state_nxt = S_RD;
        end else if (key_done) begin
          out_strobe_nxt = 1'b1;
          out_rsp_nxt    = '{status: lpht_pkg::ST_FOUND,
                             slot_index: lpht_pkg::OUT_IDX_BITS'(idx_r),
                             found_value: rec_hold_r};
          state_nxt      = S_IDLE;
        end else begin
          k_nxt     = k_r + lpht_pkg::KW_BITS'(1);
          state_nxt = S_CRD;
        end
      end
      S_WR: begin
        key_we = 1'b1;
        if (key_done) begin
          out_strobe_nxt = 1'b1;
          out_rsp_nxt    = '{status: lpht_pkg::ST_INSERTED,
                             slot_index: lpht_pkg::OUT_IDX_BITS'(idx_r),
                             found_value: '0};
          state_nxt      = S_IDLE;
        end else begin
          k_nxt = k_r + lpht_pkg::KW_BITS'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Every slot probed without a free slot or a match ends the request.
    if (state_nxt == S_RD &&
        steps_nxt == lpht_pkg::STEP_BITS'(lpht_pkg::TABLE_SLOTS)) begin
      out_strobe_nxt = 1'b1;
      out_rsp_nxt    = '{status: (req_r == lpht_pkg::REQ_INSERT) ? lpht_pkg::ST_FULL
                                                                : lpht_pkg::ST_NOT_FOUND,
                         slot_index: '0, found_value: '0};
      state_nxt      = S_IDLE;
    end

    // A finished operation drops the buffered key and the hash window.
    if (state_r != S_IDLE && state_r != S_CLEAR && state_nxt == S_IDLE) begin
      hctl.clear = 1'b1;
      count_nxt  = '0;
      ovf_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      count_r      <= '0;
      ovf_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      count_r      <= count_nxt;
      ovf_r        <= ovf_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    out_rsp_r  <= out_rsp_nxt;
    idx_r      <= idx_nxt;
    steps_r    <= steps_nxt;
    k_r        <= k_nxt;
    rec_hold_r <= rec_hold_nxt;
    if (accept) begin
      req_r <= in_req.req_type;
      rec_r <= in_req.record_value;
      len_r <= count_nxt;
      if (room) begin
        asm_r            <= asm_nxt;
        kbuf_r[pos_word] <= asm_nxt;
      end
    end
  end

endmodule

// ----- rtl/lpht_checker.sv -----
module lpht_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input lpht_pkg::in_req_t  in_req,
  input logic               out_strobe,
  input lpht_pkg::out_rsp_t out_rsp
);

  // Reset always starts the slot clearing sweep and drops any pending result.
  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> busy && !out_strobe)
    else $error("block not busy after reset");

  // A byte that does not end a key never produces a result.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_req.key_last |=> !out_strobe)
    else $error("result after a non-final byte");

  // A result is shown only once the block is free again.
  a_result_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result while busy");

  // Only a successful search carries a record value.
  a_value_only_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_rsp.status != lpht_pkg::ST_FOUND |-> out_rsp.found_value == '0)
    else $error("record value on a non-found result");

  // Failed requests report slot zero.
  a_index_only_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_rsp.status == lpht_pkg::ST_FULL ||
                   out_rsp.status == lpht_pkg::ST_NOT_FOUND ||
                   out_rsp.status == lpht_pkg::ST_REJECTED)
    |-> out_rsp.slot_index == '0)
    else $error("slot index on a failed request");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_req     (in_req),
  .out_strobe (out_strobe),
  .out_rsp    (out_rsp)
);
